@@ design/mf3_pkg.sv @@
// shared types, register codes and compare helpers for the 3x3 median filter
`default_nettype none

package mf3_pkg;

    // configuration register indexes
    localparam logic [7:0] CFG_FRAME_WIDTH  = 8'd0;
    localparam logic [7:0] CFG_FRAME_HEIGHT = 8'd1;

    // frame size after reset
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // smallest frame side that has an interior
    localparam int MIN_SIDE = 3;

    typedef logic [7:0] t_pix;

    // 3x3 window, index 0 is the upper left pixel, 8 the newest pixel
    typedef logic [8:0][7:0] t_win;

    // position and end-of-frame mark that travel with a result
    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
        logic       done;
    } t_meta;

    // three pixels in ascending order
    typedef struct packed {
        t_pix hi;
        t_pix mi;
        t_pix lo;
    } t_trio;

    function automatic t_pix min2(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix max2(input t_pix a, input t_pix b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_pix min3(input t_pix a, input t_pix b, input t_pix c);
        return min2(min2(a, b), c);
    endfunction

    function automatic t_pix max3(input t_pix a, input t_pix b, input t_pix c);
        return max2(max2(a, b), c);
    endfunction

    function automatic t_pix med3(input t_pix a, input t_pix b, input t_pix c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic t_trio sort3(input t_pix a, input t_pix b, input t_pix c);
        t_trio t;
        t.lo = min3(a, b, c);
        t.mi = med3(a, b, c);
        t.hi = max3(a, b, c);
        return t;
    endfunction

endpackage

`default_nettype wire

@@ design/mf3_line_store.sv @@
// two line stores in one synchronous memory, upper row in the high byte
`default_nettype none

module mf3_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output mf3_pkg::t_pix      o_rd_upper,
    output mf3_pkg::t_pix      o_rd_middle,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire mf3_pkg::t_pix i_wr_upper,
    input  wire mf3_pkg::t_pix i_wr_middle
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_upper, i_wr_middle};
        end
    end

    // registered read port, holds while the pipeline stalls
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_upper  = r_rd_data[15:8];
    assign o_rd_middle = r_rd_data[7:0];

endmodule

`default_nettype wire

@@ design/mf3_median.sv @@
// three-stage median of nine: row sort, column select, final median of three
`default_nettype none

module mf3_median (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire mf3_pkg::t_win  i_win,
    input  wire mf3_pkg::t_meta i_meta,
    output logic                o_valid,
    output mf3_pkg::t_pix       o_value,
    output mf3_pkg::t_meta      o_meta
);

    mf3_pkg::t_trio [2:0] r_rows;
    mf3_pkg::t_pix        r_max_lo;
    mf3_pkg::t_pix        r_med_mi;
    mf3_pkg::t_pix        r_min_hi;
    mf3_pkg::t_pix        r_value;
    mf3_pkg::t_meta       r_meta1;
    mf3_pkg::t_meta       r_meta2;
    mf3_pkg::t_meta       r_meta3;
    logic                 r_v1;
    logic                 r_v2;
    logic                 r_v3;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // sort each window row, then reduce columns, then take median of three
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_rows[k] <= mf3_pkg::sort3(i_win[3*k], i_win[3*k+1], i_win[3*k+2]);
            end
            r_meta1  <= i_meta;
            r_max_lo <= mf3_pkg::max3(r_rows[0].lo, r_rows[1].lo, r_rows[2].lo);
            r_med_mi <= mf3_pkg::med3(r_rows[0].mi, r_rows[1].mi, r_rows[2].mi);
            r_min_hi <= mf3_pkg::min3(r_rows[0].hi, r_rows[1].hi, r_rows[2].hi);
            r_meta2  <= r_meta1;
            r_value  <= mf3_pkg::med3(r_max_lo, r_med_mi, r_min_hi);
            r_meta3  <= r_meta2;
        end
    end

    assign o_valid = r_v3;
    assign o_value = r_value;
    assign o_meta  = r_meta3;

endmodule

`default_nettype wire

@@ design/median_filter_3x3.sv @@
// top level of the 3x3 median filter: counters, line store access, window, output
//
//  channel  | dir | handshake                | contents
//  ---------+-----+--------------------------+-------------------------------------
//  s        | in  | i_s_tvalid / o_s_tready  | tdata: pixel
//  m        | out | o_m_tvalid / i_m_tready  | tdata: median, row, column; tlast: frame done
//  cfg      | in  | i_cfg_valid / o_cfg_ready| index 0 frame width, 1 frame height
//
// one pixel per clock unless the output stalls; the line store has one read and
// one write port, and a pixel reads its column in the cycle it is accepted and
// writes it back as it leaves stage 0, so no two neighbors touch the same entry.
// a result follows the pixel below and right of its center through stage 0, the window and the median pipeline.
// the whole pipeline halts while a finished word waits at the output.
// reset clears counters and valids; line stores need no clearing pass.
`default_nettype none

module median_filter_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] pixel
    // master stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [7:0] median_value, [17:8] center_row,
                                          // [27:18] center_column, [31:28] zero
    output logic             o_m_tlast,   // frame_done
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int RST_W_LAST = (mf3_pkg::RESET_WIDTH > MAX_WIDTH) ?
                                MAX_WIDTH - 1 : mf3_pkg::RESET_WIDTH - 1;
    localparam int RST_H_LAST = (mf3_pkg::RESET_HEIGHT > MAX_HEIGHT) ?
                                MAX_HEIGHT - 1 : mf3_pkg::RESET_HEIGHT - 1;

    logic [CW-1:0]   r_w_last;
    logic [RW-1:0]   r_h_last;
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic            adv;
    logic            accept;
    logic            cfg_wr;
    logic            col_last;
    logic            row_last;
    logic            emit;
    mf3_pkg::t_meta  meta;

    // stage 0: accepted pixel waiting for its line store read
    logic            r_s0_valid;
    logic            r_s0_emit;
    mf3_pkg::t_pix   r_s0_px;
    logic [CW-1:0]   r_s0_col;
    mf3_pkg::t_meta  r_s0_meta;
    mf3_pkg::t_pix   rd_upper;
    mf3_pkg::t_pix   rd_middle;

    // stage 1: window
    mf3_pkg::t_win   r_win;
    logic            r_s1_valid;
    mf3_pkg::t_meta  r_s1_meta;

    logic            med_valid;
    mf3_pkg::t_pix   med_value;
    mf3_pkg::t_meta  med_meta;

    // the pipeline moves whenever the output word is empty or being taken
    assign adv         = !med_valid || i_m_tready;
    assign o_s_tready  = adv;
    assign accept      = i_s_tvalid && adv;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    // position of the incoming pixel
    assign col_last = (r_col == r_w_last);
    assign row_last = (r_row == r_h_last);
    assign emit     = (32'(r_row) >= 32'd2) && (32'(r_col) >= 32'd2);
    assign meta.row  = 10'(32'(r_row) - 32'd1);
    assign meta.col  = 10'(32'(r_col) - 32'd1);
    assign meta.done = row_last && col_last;

    // frame size registers, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= CW'(RST_W_LAST);
            r_h_last <= RW'(RST_H_LAST);
        end else if (cfg_wr) begin
            case (i_cfg_index)
                mf3_pkg::CFG_FRAME_WIDTH: begin
                    if (32'(i_cfg_data) < mf3_pkg::MIN_SIDE) begin
                        r_w_last <= CW'(mf3_pkg::MIN_SIDE - 1);
                    end else if (32'(i_cfg_data) > MAX_WIDTH) begin
                        r_w_last <= CW'(MAX_WIDTH - 1);
                    end else begin
                        r_w_last <= CW'(32'(i_cfg_data) - 32'd1);
                    end
                end
                mf3_pkg::CFG_FRAME_HEIGHT: begin
                    if (32'(i_cfg_data) < mf3_pkg::MIN_SIDE) begin
                        r_h_last <= RW'(mf3_pkg::MIN_SIDE - 1);
                    end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
                        r_h_last <= RW'(MAX_HEIGHT - 1);
                    end else begin
                        r_h_last <= RW'(32'(i_cfg_data) - 32'd1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // raster counters, restarted by any valid register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_wr && (i_cfg_index == mf3_pkg::CFG_FRAME_WIDTH ||
                                i_cfg_index == mf3_pkg::CFG_FRAME_HEIGHT)) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // line stores: read on accept, write back when the word leaves stage 0
    mf3_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .i_clk       (i_clk),
        .i_rd_en     (accept),
        .i_rd_addr   (r_col),
        .o_rd_upper  (rd_upper),
        .o_rd_middle (rd_middle),
        .i_wr_en     (adv && r_s0_valid),
        .i_wr_addr   (r_s0_col),
        .i_wr_upper  (rd_middle),
        .i_wr_middle (r_s0_px)
    );

    // stage 0 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (adv) begin
            r_s0_valid <= accept;
        end
    end

    // stage 0 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0_px   <= i_s_tdata;
            r_s0_col  <= r_col;
            r_s0_emit <= emit;
            r_s0_meta <= meta;
        end
    end

    // stage 1 control, only interior pixels go on to the median
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= r_s0_valid && r_s0_emit;
        end
    end

    // window shift: new column on the right
    always_ff @(posedge i_clk) begin
        if (adv && r_s0_valid) begin
            r_win[0]  <= r_win[1];
            r_win[1]  <= r_win[2];
            r_win[2]  <= rd_upper;
            r_win[3]  <= r_win[4];
            r_win[4]  <= r_win[5];
            r_win[5]  <= rd_middle;
            r_win[6]  <= r_win[7];
            r_win[7]  <= r_win[8];
            r_win[8]  <= r_s0_px;
            r_s1_meta <= r_s0_meta;
        end
    end

    // median pipeline, its last stage is the output word
    mf3_median u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_s1_valid),
        .i_win   (r_win),
        .i_meta  (r_s1_meta),
        .o_valid (med_valid),
        .o_value (med_value),
        .o_meta  (med_meta)
    );

    assign o_m_tvalid = med_valid;
    assign o_m_tdata  = {4'b0000, med_meta.col, med_meta.row, med_value};
    assign o_m_tlast  = med_meta.done;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking testbench for median_filter_3x3: directed frames, then random frames
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_SIDE       = 1024;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 40;
    localparam int DIR_ROWS       = 14;
    localparam logic [7:0] CFG_BAD_INDEX = 8'hFF;

    typedef enum logic [1:0] {FILL_CONST, FILL_RAMP, FILL_ALT, FILL_RAND} t_fill;

    // one expected output word
    typedef struct {
        mf3_pkg::t_pix med;
        logic [9:0]    row;
        logic [9:0]    col;
        logic          done;
    } t_median_word;

    // one directed frame; npix of zero means a whole frame
    typedef struct {
        logic          wr_cfg;
        logic [10:0]   w_val;
        logic [10:0]   h_val;
        logic          wr_bad;
        int            npix;
        t_fill         fill;
        mf3_pkg::t_pix base;
        logic          typed;
        mf3_pkg::t_pix typed_med;
    } t_dir_case;

    t_dir_case dir_cases [DIR_ROWS] = '{
        '{1'b0, 11'd640,  11'd480,  1'b0, 12,   FILL_CONST, 8'd77,  1'b1, 8'd77},
        '{1'b1, 11'd3,    11'd3,    1'b0, 0,    FILL_CONST, 8'd0,   1'b1, 8'd0},
        '{1'b1, 11'd3,    11'd3,    1'b0, 0,    FILL_CONST, 8'd255, 1'b1, 8'd255},
        '{1'b1, 11'd3,    11'd3,    1'b0, 0,    FILL_RAMP,  8'd0,   1'b1, 8'd4},
        '{1'b1, 11'd0,    11'd1,    1'b0, 0,    FILL_CONST, 8'd128, 1'b1, 8'd128},
        '{1'b1, 11'd2,    11'd2,    1'b0, 0,    FILL_RAND,  8'd0,   1'b0, 8'd0},
        '{1'b1, 11'd3,    11'd3,    1'b1, 0,    FILL_RAND,  8'd0,   1'b0, 8'd0},
        '{1'b1, 11'd4,    11'd4,    1'b0, 6,    FILL_RAND,  8'd0,   1'b0, 8'd0},
        '{1'b0, 11'd4,    11'd4,    1'b1, 10,   FILL_RAND,  8'd0,   1'b0, 8'd0},
        '{1'b1, 11'd5,    11'd3,    1'b0, 0,    FILL_ALT,   8'd0,   1'b0, 8'd0},
        '{1'b1, 11'd3,    11'd6,    1'b0, 0,    FILL_RAMP,  8'd250, 1'b0, 8'd0},
        '{1'b1, 11'd6,    11'd5,    1'b0, 0,    FILL_RAND,  8'd0,   1'b0, 8'd0},
        '{1'b1, 11'd1025, 11'd3,    1'b0, 40,   FILL_RAND,  8'd0,   1'b0, 8'd0},
        '{1'b1, 11'd3,    11'd2047, 1'b0, 30,   FILL_RAND,  8'd0,   1'b0, 8'd0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;    // [7:0] pixel
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;    // [7:0] median, [17:8] row, [27:18] column, [31:28] zero
    logic        o_m_tlast;    // frame done
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [10:0] i_cfg_data;

    // filter model state
    mf3_pkg::t_pix upper_line  [MAX_SIDE];
    mf3_pkg::t_pix middle_line [MAX_SIDE];
    mf3_pkg::t_win window;
    logic [9:0]    col_pos;
    logic [9:0]    row_pos;
    logic [10:0]   frame_w_reg;
    logic [10:0]   frame_h_reg;
    logic          typed_on;
    mf3_pkg::t_pix typed_med;

    t_median_word pending_medians [$];
    int           mismatches;
    int           src_idle;
    int           sink_stall;
    logic         hold_req;

    median_filter_3x3 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // register value to the frame side actually used
    function automatic logic [10:0] eff_side(input logic [10:0] v);
        if (v < mf3_pkg::MIN_SIDE) return 11'(mf3_pkg::MIN_SIDE);
        if (v > MAX_SIDE) return 11'(MAX_SIDE);
        return v;
    endfunction

    // fifth smallest of nine: the value with at most four below it and at least five at or below
    function automatic mf3_pkg::t_pix median_of9(input mf3_pkg::t_win w);
        int below;
        int upto;
        for (int i = 0; i < 9; i++) begin
            below = 0;
            upto  = 0;
            for (int j = 0; j < 9; j++) begin
                if (w[j] < w[i]) below++;
                if (w[j] <= w[i]) upto++;
            end
            if (below <= 4 && upto > 4) return w[i];
        end
        return '0;
    endfunction

    function automatic mf3_pkg::t_pix pixel_at(input t_fill fill, input mf3_pkg::t_pix base,
                                               input int k);
        case (fill)
            FILL_CONST: return base;
            FILL_RAMP:  return base + mf3_pkg::t_pix'(k);
            FILL_ALT:   return (k % 2 != 0) ? 8'hFF : 8'h00;
            default:    return mf3_pkg::t_pix'($urandom);
        endcase
    endfunction

    function automatic logic [10:0] pick_side();
        if ($urandom_range(99) < 12) return 11'($urandom_range(2));
        return 11'($urandom_range(8, 3));
    endfunction

    function automatic int frame_pixels();
        return int'(eff_side(frame_w_reg)) * int'(eff_side(frame_h_reg));
    endfunction

    // advance the model by one pixel and queue the median it causes, if any
    task automatic filter_pixel(input mf3_pkg::t_pix p);
        logic [10:0]   w_eff;
        logic [10:0]   h_eff;
        logic [9:0]    c;
        logic [9:0]    r;
        mf3_pkg::t_win old;
        t_median_word  word;
        w_eff = eff_side(frame_w_reg);
        h_eff = eff_side(frame_h_reg);
        c     = col_pos;
        r     = row_pos;
        old   = window;
        // slide one column left, new column enters on the right
        window[0] = old[1];
        window[1] = old[2];
        window[2] = upper_line[c];
        window[3] = old[4];
        window[4] = old[5];
        window[5] = middle_line[c];
        window[6] = old[7];
        window[7] = old[8];
        window[8] = p;
        upper_line[c]  = middle_line[c];
        middle_line[c] = p;
        // interior center once three rows and three columns are in
        if (r >= 2 && c >= 2) begin
            word.med  = typed_on ? typed_med : median_of9(window);
            word.row  = r - 10'd1;
            word.col  = c - 10'd1;
            word.done = ({1'b0, r} + 11'd1 == h_eff) && ({1'b0, c} + 11'd1 == w_eff);
            pending_medians = {pending_medians, word};
        end
        // raster counters
        if ({1'b0, c} + 11'd1 >= w_eff) begin
            col_pos = '0;
            row_pos = ({1'b0, r} + 11'd1 >= h_eff) ? '0 : r + 10'd1;
        end else begin
            col_pos = c + 10'd1;
        end
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [10:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        // a valid index restarts the frame
        if (idx == mf3_pkg::CFG_FRAME_WIDTH) begin
            frame_w_reg = val;
            col_pos     = '0;
            row_pos     = '0;
        end else if (idx == mf3_pkg::CFG_FRAME_HEIGHT) begin
            frame_h_reg = val;
            col_pos     = '0;
            row_pos     = '0;
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // offer one pixel, with random idle cycles ahead of it; returns at a falling edge
    task automatic send_pixel(input mf3_pkg::t_pix p);
        while ($urandom_range(99) < src_idle) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = p;
        do @(posedge i_clk); while (!o_s_tready);
        filter_pixel(p);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input int npix, input t_fill fill, input mf3_pkg::t_pix base);
        for (int k = 0; k < npix; k++) send_pixel(pixel_at(fill, base, k));
    endtask

    // stop sending, wait for every median, then let the pipeline run dry
    task automatic settle();
        i_s_tvalid = 1'b0;
        while (pending_medians.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic report(input string field, input logic [31:0] want,
                          input logic [31:0] got);
        if (mismatches < 10)
            $display("mismatch %s: expected %h, got %h", field, want, got);
        mismatches++;
    endtask

    // output side: compare each word with the oldest expectation
    always @(posedge i_clk) begin : output_check
        t_median_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_medians.size() == 0) begin
                report("unexpected word", '0, o_m_tdata);
            end else begin
                want = pending_medians.pop_front();
                if (o_m_tdata[7:0] !== want.med)
                    report("median_value", 32'(want.med), 32'(o_m_tdata[7:0]));
                if (o_m_tdata[17:8] !== want.row)
                    report("center_row", 32'(want.row), 32'(o_m_tdata[17:8]));
                if (o_m_tdata[27:18] !== want.col)
                    report("center_column", 32'(want.col), 32'(o_m_tdata[27:18]));
                if (o_m_tdata[31:28] !== 4'd0)
                    report("tdata padding", '0, 32'(o_m_tdata[31:28]));
                if (o_m_tlast !== want.done)
                    report("frame_done", 32'(want.done), 32'(o_m_tlast));
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin : receiver
        bit hold_served;
        hold_served = 1'b0;
        i_m_tready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_served) begin
                i_m_tready  = 1'b0;
                hold_served = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_m_tready = ($urandom_range(99) >= sink_stall);
        end
    end

    // watchdog: too many cycles without any word moving
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin : stimulus
        int    roll;
        int    npix;
        t_fill fill;
        int    phase_items;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        hold_req    = 1'b0;
        src_idle    = 0;
        sink_stall  = 0;
        typed_on    = 1'b0;
        typed_med   = '0;
        mismatches  = 0;
        window      = '0;
        col_pos     = '0;
        row_pos     = '0;
        frame_w_reg = 11'(mf3_pkg::RESET_WIDTH);
        frame_h_reg = 11'(mf3_pkg::RESET_HEIGHT);
        for (int i = 0; i < MAX_SIDE; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed frames
        foreach (dir_cases[i]) begin
            if (dir_cases[i].wr_cfg || dir_cases[i].wr_bad) settle();
            if (dir_cases[i].wr_cfg) begin
                cfg_write(mf3_pkg::CFG_FRAME_WIDTH, dir_cases[i].w_val);
                cfg_write(mf3_pkg::CFG_FRAME_HEIGHT, dir_cases[i].h_val);
            end
            // bad index carries a legal size that must not land anywhere
            if (dir_cases[i].wr_bad) cfg_write(CFG_BAD_INDEX, 11'd5);
            typed_on  = dir_cases[i].typed;
            typed_med = dir_cases[i].typed_med;
            npix = (dir_cases[i].npix != 0) ? dir_cases[i].npix : frame_pixels();
            send_frame(npix, dir_cases[i].fill, dir_cases[i].base);
        end
        typed_on = 1'b0;

        // back to a small frame before the random part
        settle();
        cfg_write(mf3_pkg::CFG_FRAME_WIDTH, 11'd6);
        cfg_write(mf3_pkg::CFG_FRAME_HEIGHT, 11'd6);

        // random frames under each idling pattern, last phase with a long hold-off
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1:       begin src_idle = 79; sink_stall = 0;  end
                2:       begin src_idle = 0;  sink_stall = 79; end
                3:       begin src_idle = 20; sink_stall = 20; end
                default: begin src_idle = 0;  sink_stall = 0;  end
            endcase
            phase_items = 0;
            if (ph == 4) begin
                settle();
                cfg_write(mf3_pkg::CFG_FRAME_WIDTH, 11'd8);
                cfg_write(mf3_pkg::CFG_FRAME_HEIGHT, 11'd8);
                hold_req = 1'b1;
                send_frame(64, FILL_RAND, 8'd0);
            end
            while (phase_items < PHASE_ITEMS) begin
                roll = $urandom_range(99);
                // most frames start from a fresh size; the rest run straight on
                if (roll < 70) begin
                    settle();
                    cfg_write(mf3_pkg::CFG_FRAME_WIDTH, pick_side());
                    if (roll < 60) cfg_write(mf3_pkg::CFG_FRAME_HEIGHT, pick_side());
                    if (roll < 10)
                        cfg_write(8'($urandom_range(255, 2)), 11'($urandom_range(2047)));
                end
                npix = frame_pixels();
                if ($urandom_range(7) == 0) npix = $urandom_range(npix - 1, 1);
                fill = ($urandom_range(3) != 0) ? FILL_RAND : t_fill'($urandom_range(3));
                send_frame(npix, fill, mf3_pkg::t_pix'($urandom));
                phase_items += npix;
            end
        end

        settle();
        if (mismatches == 0 && pending_medians.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
